FILE: src/pot_sample_to_angle_macros.svh
// ----------------------------------------------------------------------------
// pot_sample_to_angle_macros
// assertion shorthands, each sampled on clk and muted while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POT_SAMPLE_TO_ANGLE_MACROS_SVH
`define POT_SAMPLE_TO_ANGLE_MACROS_SVH

// same-cycle implication
`define PST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pst assertion failed");

// next-cycle implication
`define PST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pst assertion failed");

`endif

FILE: src/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// shared constants and types of the potentiometer-to-angle converter
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  // full scale in degrees and the integer bits it takes
  localparam int DEG_FULL = 90;
  localparam int DEG_BITS = 7;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLOSED = 2'd0,
    REG_OPEN   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic bad;
    logic snap_lo;
    logic snap_hi;
  } pst_flags_t;

endpackage

FILE: src/pst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_if
// valid/ready channels for samples, angles and register writes
// ----------------------------------------------------------------------------
interface pst_in_if
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pst_out_if
  import pst_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
  localparam int ANGLE_BITS = FRAC_BITS + DEG_BITS;

  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_q8;
  logic                  calibration_bad;

  modport source (output valid, output angle_q8, output calibration_bad, input ready);
  modport sink   (input valid, input angle_q8, input calibration_bad, output ready);
endinterface

interface pst_cfg_if
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [SAMPLE_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/pot_sample_to_angle.sv
`timescale 1ns / 1ps
// pipeline from input transfer to result:
//   three setup stages, one divider stage per angle bit, one result register
// throughput: one sample per cycle while out_ch.ready holds; each stage advances on its own, so bubbles close up
// reset: pipeline emptied, closed_reading cleared to 0, open_reading set to all ones
// ----------------------------------------------------------------------------
// pot_sample_to_angle
// two-point calibrated conversion of a pot sample to a 0..90 degree angle
// ----------------------------------------------------------------------------
module pot_sample_to_angle
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pst_in_if.sink        in_ch,
  pst_out_if.source     out_ch,
  pst_cfg_if.sink       cfg_ch
);

  localparam int Q_BITS = FRAC_BITS + DEG_BITS;

  logic [SAMPLE_BITS-1:0] closed_r;
  logic [SAMPLE_BITS-1:0] open_r;

  logic                   v_w     [0:Q_BITS];
  logic                   rdy_w   [0:Q_BITS];
  logic [SAMPLE_BITS-1:0] rem_w   [0:Q_BITS];
  logic [Q_BITS-1:0]      tail_w  [0:Q_BITS];
  logic [Q_BITS-1:0]      quot_w  [0:Q_BITS];
  logic [SAMPLE_BITS-1:0] span_w  [0:Q_BITS];
  pst_flags_t             flags_w [0:Q_BITS];

  // calibration registers; the user must write them only while idle, the block itself does not enforce it
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= '0;
      open_r   <= '1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CLOSED: closed_r <= cfg_ch.data;
        REG_OPEN:   open_r   <= cfg_ch.data;
        default:    ;
      endcase
    end
  end

  pst_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .sample         (in_ch.sample),
    .closed_reading (closed_r),
    .open_reading   (open_r),
    .out_valid      (v_w[0]),
    .out_ready      (rdy_w[0]),
    .rem            (rem_w[0]),
    .tail           (tail_w[0]),
    .span           (span_w[0]),
    .flags          (flags_w[0])
  );

  assign quot_w[0] = '0;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    pst_div_stage #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_w[k]),
      .in_ready  (rdy_w[k]),
      .in_rem    (rem_w[k]),
      .in_tail   (tail_w[k]),
      .in_quot   (quot_w[k]),
      .in_span   (span_w[k]),
      .in_flags  (flags_w[k]),
      .out_valid (v_w[k+1]),
      .out_ready (rdy_w[k+1]),
      .out_rem   (rem_w[k+1]),
      .out_tail  (tail_w[k+1]),
      .out_quot  (quot_w[k+1]),
      .out_span  (span_w[k+1]),
      .out_flags (flags_w[k+1])
    );
  end

  pst_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (v_w[Q_BITS]),
    .in_ready        (rdy_w[Q_BITS]),
    .quot            (quot_w[Q_BITS]),
    .flags           (flags_w[Q_BITS]),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .angle_q8        (out_ch.angle_q8),
    .calibration_bad (out_ch.calibration_bad)
  );

endmodule

FILE: src/pst_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_prep
// clamp, scale by 90 and snap tests; sets up the divider operands
// ----------------------------------------------------------------------------
module pst_prep
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [SAMPLE_BITS-1:0]           closed_reading,
  input  logic [SAMPLE_BITS-1:0]           open_reading,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SAMPLE_BITS-1:0]           rem,
  output logic [FRAC_BITS+DEG_BITS-1:0]    tail,
  output logic [SAMPLE_BITS-1:0]           span,
  output pst_flags_t                       flags
);

  localparam int NUM_BITS = SAMPLE_BITS + DEG_BITS;

  // stage a: clamp and offset
  logic                   va_r;
  logic                   bad_a_r;
  logic [SAMPLE_BITS-1:0] d_a_r;
  logic [SAMPLE_BITS-1:0] span_a_r;
  // stage b: products
  logic                   vb_r;
  logic                   bad_b_r;
  logic [NUM_BITS-1:0]    num_b_r;
  logic [NUM_BITS-1:0]    span89_b_r;
  logic [SAMPLE_BITS-1:0] span_b_r;
  // stage c: divider operands and snap flags
  logic                   vc_r;
  pst_flags_t             flags_c_r;
  logic [NUM_BITS-1:0]    num_c_r;
  logic [SAMPLE_BITS-1:0] span_c_r;

  logic                   rdy_a;
  logic                   rdy_b;
  logic                   rdy_c;
  logic [SAMPLE_BITS-1:0] s_clamp;
  pst_flags_t             flags_nxt;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    priority if (sample < closed_reading) begin
      s_clamp = closed_reading;
    end else if (sample > open_reading) begin
      s_clamp = open_reading;
    end else begin
      s_clamp = sample;
    end
  end

  always_comb begin
    flags_nxt.bad     = bad_b_r;
    flags_nxt.snap_lo = num_b_r < NUM_BITS'(span_b_r);
    flags_nxt.snap_hi = num_b_r > span89_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      bad_a_r  <= open_reading <= closed_reading;
      d_a_r    <= s_clamp - closed_reading;
      span_a_r <= open_reading - closed_reading;
    end
    if (rdy_b) begin
      bad_b_r    <= bad_a_r;
      num_b_r    <= NUM_BITS'(d_a_r) * NUM_BITS'(DEG_FULL);
      span89_b_r <= NUM_BITS'(span_a_r) * NUM_BITS'(DEG_FULL - 1);
      span_b_r   <= span_a_r;
    end
    if (rdy_c) begin
      flags_c_r <= flags_nxt;
      num_c_r   <= num_b_r;
      span_c_r  <= span_b_r;
    end
  end

  // for a good calibration num < 128*span, so the upper part already sits below the divisor
  assign out_valid = vc_r;
  assign rem       = num_c_r[NUM_BITS-1:DEG_BITS];
  assign tail      = {num_c_r[DEG_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign span      = span_c_r;
  assign flags     = flags_c_r;

endmodule

FILE: src/pst_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_div_stage
// one restoring-division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module pst_div_stage
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_rem,
  input  logic [FRAC_BITS+DEG_BITS-1:0] in_tail,
  input  logic [FRAC_BITS+DEG_BITS-1:0] in_quot,
  input  logic [SAMPLE_BITS-1:0]        in_span,
  input  pst_flags_t                    in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_rem,
  output logic [FRAC_BITS+DEG_BITS-1:0] out_tail,
  output logic [FRAC_BITS+DEG_BITS-1:0] out_quot,
  output logic [SAMPLE_BITS-1:0]        out_span,
  output pst_flags_t                    out_flags
);

  localparam int Q_BITS = FRAC_BITS + DEG_BITS;

  logic                   v_r;
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [Q_BITS-1:0]      tail_r;
  logic [Q_BITS-1:0]      quot_r;
  logic [SAMPLE_BITS-1:0] span_r;
  pst_flags_t             flags_r;

  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;
  logic [SAMPLE_BITS-1:0] rem_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    trial   = {in_rem, in_tail[Q_BITS-1]};
    fits    = trial >= {1'b0, in_span};
    rem_nxt = fits ? SAMPLE_BITS'(trial - {1'b0, in_span}) : trial[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r   <= rem_nxt;
      tail_r  <= {in_tail[Q_BITS-2:0], 1'b0};
      quot_r  <= {in_quot[Q_BITS-2:0], fits};
      span_r  <= in_span;
      flags_r <= in_flags;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_tail  = tail_r;
  assign out_quot  = quot_r;
  assign out_span  = span_r;
  assign out_flags = flags_r;

endmodule

FILE: src/pst_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_finish
// applies bad-calibration and endpoint snapping, holds the result register
// ----------------------------------------------------------------------------
module pst_finish
  import pst_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FRAC_BITS+DEG_BITS-1:0] quot,
  input  pst_flags_t                    flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRAC_BITS+DEG_BITS-1:0] angle_q8,
  output logic                          calibration_bad
);

  localparam int ANGLE_BITS = FRAC_BITS + DEG_BITS;
  localparam logic [ANGLE_BITS-1:0] FULL_Q = ANGLE_BITS'(DEG_FULL << FRAC_BITS);

  logic                  v_r;
  logic [ANGLE_BITS-1:0] angle_r;
  logic                  bad_r;
  logic [ANGLE_BITS-1:0] angle_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    priority if (flags.bad || flags.snap_lo) begin
      angle_nxt = '0;
    end else if (flags.snap_hi) begin
      angle_nxt = FULL_Q;
    end else begin
      angle_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      angle_r <= angle_nxt;
      bad_r   <= flags.bad;
    end
  end

  assign out_valid       = v_r;
  assign angle_q8        = angle_r;
  assign calibration_bad = bad_r;

endmodule

FILE: src/pst_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_chk
// port-level checks on the result channel of pot_sample_to_angle
// ----------------------------------------------------------------------------
`include "pot_sample_to_angle_macros.svh"

module pst_chk
  import pst_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [FRAC_BITS+DEG_BITS-1:0] angle_q8,
  input logic                          calibration_bad
);

  localparam int ANGLE_BITS = FRAC_BITS + DEG_BITS;
  localparam logic [ANGLE_BITS-1:0] ONE_DEG  = ANGLE_BITS'(1 << FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] LAST_DEG = ANGLE_BITS'((DEG_FULL - 1) << FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] FULL_Q   = ANGLE_BITS'(DEG_FULL << FRAC_BITS);

  // bad calibration always reports a zero angle
  `PST_ASSERT_NOW(a_bad_zero, out_valid && calibration_bad, angle_q8 == '0)

  // snapping leaves no angle strictly inside the first or last degree
  `PST_ASSERT_NOW(a_snap_gap, out_valid,
                  angle_q8 == '0 || angle_q8 == FULL_Q ||
                  (angle_q8 >= ONE_DEG && angle_q8 <= LAST_DEG))

  // a held result stays put until its transfer
  `PST_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                   out_valid && $stable(angle_q8) && $stable(calibration_bad))

endmodule

bind pot_sample_to_angle pst_chk #(
  .FRAC_BITS (FRAC_BITS)
) u_pst_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .angle_q8        (out_ch.angle_q8),
  .calibration_bad (out_ch.calibration_bad)
);

FILE: sim/pot_sample_to_angle_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_sample_to_angle_monitor
// watches the sample, angle and register channels, predicts each angle from
// the calibration it has seen written and compares it with what comes out
// ----------------------------------------------------------------------------
module pot_sample_to_angle_monitor
  import pst_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pst_in_if    in_ch,
  pst_out_if   out_ch,
  pst_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int ANGLE_BITS = FRAC_BITS + DEG_BITS;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_q8;
    logic                  calibration_bad;
  } angle_result_t;

  logic [SAMPLE_BITS-1:0] closed_cal;
  logic [SAMPLE_BITS-1:0] open_cal;
  angle_result_t          angle_fifo[$];

  // two-point scaling with snap to either end within one degree
  function automatic angle_result_t scale_to_angle(input logic [SAMPLE_BITS-1:0] s,
                                                   input logic [SAMPLE_BITS-1:0] lo,
                                                   input logic [SAMPLE_BITS-1:0] hi);
    angle_result_t          r;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [63:0]            span;
    logic [63:0]            scaled;
    r = '0;
    if (hi <= lo) begin
      r.calibration_bad = 1'b1;
      return r;
    end
    clamped = (s < lo) ? lo : ((s > hi) ? hi : s);
    span    = 64'(hi - lo);
    scaled  = 64'(clamped - lo) * 64'(DEG_FULL);
    if (scaled < span) begin
      r.angle_q8 = '0;
    end else if (scaled > 64'(DEG_FULL - 1) * span) begin
      r.angle_q8 = ANGLE_BITS'(DEG_FULL << FRAC_BITS);
    end else begin
      r.angle_q8 = ANGLE_BITS'((scaled << FRAC_BITS) / span);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    angle_result_t want;
    if (!rst_n) begin
      closed_cal = '0;
      open_cal   = '1;
      angle_fifo.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        angle_fifo.push_back(scale_to_angle(in_ch.sample, closed_cal, open_cal));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (angle_fifo.size() == 0) begin
          fail_count++;
          $display("%0t: angle transfer with none expected: angle_q8=%0d calibration_bad=%0b",
                   $time, out_ch.angle_q8, out_ch.calibration_bad);
        end else begin
          want = angle_fifo.pop_front();
          if (out_ch.angle_q8 !== want.angle_q8) begin
            fail_count++;
            $display("%0t: angle_q8 expected %0d, got %0d", $time, want.angle_q8,
                     out_ch.angle_q8);
          end
          if (out_ch.calibration_bad !== want.calibration_bad) begin
            fail_count++;
            $display("%0t: calibration_bad expected %0b, got %0b", $time,
                     want.calibration_bad, out_ch.calibration_bad);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_CLOSED: closed_cal = cfg_ch.data;
          REG_OPEN:   open_cal = cfg_ch.data;
          default: ;
        endcase
      end
    end
    pending = angle_fifo.size();
  end

endmodule

FILE: sim/pot_sample_to_angle_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_sample_to_angle_test
// drives samples and calibration writes into the angle converter under
// several idle and stall mixes; the monitor beside it checks every angle
// ----------------------------------------------------------------------------
module pot_sample_to_angle_test;
  import pst_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int FB            = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 2 * (FB + 11);
  localparam int CYCLE_LIMIT   = 300000;
  localparam int BLOCK_ITEMS   = 50;
  localparam int BLOCKS        = 5;
  // no register lives at this index
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   hold_off    = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;

  pst_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  pst_out_if #(.FRAC_BITS(FB))   out_ch ();
  pst_cfg_if #(.SAMPLE_BITS(SB)) cfg_ch ();

  pot_sample_to_angle #(.SAMPLE_BITS(SB), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pot_sample_to_angle_monitor #(.SAMPLE_BITS(SB), .FRAC_BITS(FB)) angle_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // angle receiver: a long hold-off when asked, random stalls otherwise
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready = 1'b0;
        hold_off--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [SB-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [SB-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // hold the sender until every angle is back and the pipeline is empty
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_calibration(input logic [SB-1:0] closed_v, input logic [SB-1:0] open_v);
    wait_drained();
    write_reg(REG_CLOSED, closed_v);
    write_reg(REG_OPEN, open_v);
  endtask

  // as many samples anywhere as inside the calibrated span, the rest near its ends
  function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] lo, input logic [SB-1:0] hi);
    int unsigned sel;
    int          v;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return SB'($urandom);
    end else if (sel < 8) begin
      return SB'($urandom_range(int'(hi), int'(lo)));
    end
    v = ((sel == 8) ? int'(lo) : int'(hi)) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > (1 << SB) - 1) v = (1 << SB) - 1;
    return SB'(v);
  endfunction

  task automatic random_calibration(output logic [SB-1:0] lo, output logic [SB-1:0] hi);
    int unsigned sel;
    logic [SB-1:0] a;
    logic [SB-1:0] b;
    sel = $urandom_range(9);
    a   = SB'($urandom);
    b   = SB'($urandom);
    case (sel)
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        // open at or below closed
        lo = a;
        hi = SB'($urandom_range(int'(a)));
      end
      2: begin
        lo = SB'($urandom_range((1 << SB) - 5));
        hi = lo + SB'($urandom_range(4, 1));
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
  endtask

  initial begin
    logic [SB-1:0] full_pts[]  = '{12'd0, 12'd45, 12'd46, 12'd4049, 12'd4050, 12'd4095,
                                   12'hAAA, 12'h555};
    logic [SB-1:0] mid_pts[]   = '{12'd999, 12'd1022, 12'd1023, 12'd2000, 12'd2978,
                                   12'd4095};
    int idle_modes[4]  = '{0, 79, 0, 21};
    int stall_modes[4] = '{0, 0, 79, 21};
    logic [SB-1:0] lo;
    logic [SB-1:0] hi;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CLOSED;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset calibration covers the whole sample range
    foreach (full_pts[i]) send_sample(full_pts[i]);

    set_calibration(12'd1000, 12'd3000);
    foreach (mid_pts[i]) send_sample(mid_pts[i]);

    // open equal to closed, then below it
    set_calibration(12'd2000, 12'd2000);
    send_sample(12'd0);
    send_sample(12'd4095);
    wait_drained();
    write_reg(REG_SPARE, 12'd5);
    set_calibration(12'd4095, 12'd0);
    send_sample(12'd2048);

    // one-count spans at both ends of the range
    set_calibration(12'd0, 12'd1);
    send_sample(12'd0);
    send_sample(12'd1);
    set_calibration(12'd4094, 12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);

    for (int m = 0; m < 4; m++) begin
      wait_drained();
      idle_pct  = idle_modes[m];
      stall_pct = stall_modes[m];
      for (int blk = 0; blk < BLOCKS; blk++) begin
        random_calibration(lo, hi);
        set_calibration(lo, hi);
        // back up the pipeline so that it stalls its input
        if (m == 0 && blk == 0) hold_off = 300;
        for (int n = 0; n < BLOCK_ITEMS; n++) send_sample(pick_sample(lo, hi));
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
